// ----- hdl/bir_pkg.sv -----
// Package for the burner ignition retry controller.
// Holds field widths, codes, register reset values and the item, result and config types.
// No dependencies.
package bir_pkg;

  localparam int unsigned TIMER_BITS = 16;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned CMP_W      = (TIMER_BITS > LIMIT_W) ? TIMER_BITS : LIMIT_W;

  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned STATE_W    = 2;
  localparam int unsigned ATTEMPT_W  = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK         = 2'd0,
    ACT_MANUAL_RESET = 2'd1,
    ACT_CLEAR_ALARM  = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAS_HEATING       = 3'd0,
    REG_IGNITION_ATTEMPTS = 3'd1,
    REG_ALARM_DELAY_MS    = 3'd2,
    REG_RESET_PULSE_MS    = 3'd3,
    REG_DEBOUNCE_MS       = 3'd4
  } cfg_idx_e;

  localparam logic [STATE_W-1:0] BS_OK        = 2'd0;
  localparam logic [STATE_W-1:0] BS_RESETTING = 2'd1;
  localparam logic [STATE_W-1:0] BS_DEBOUNCE  = 2'd2;
  localparam logic [STATE_W-1:0] BS_LOCKED    = 2'd3;

  typedef enum logic [3:0] {
    MODE_OK        = 4'b0001,
    MODE_RESETTING = 4'b0010,
    MODE_DEBOUNCE  = 4'b0100,
    MODE_LOCKED    = 4'b1000
  } mode_e;

  localparam logic                 RST_GAS_HEATING       = 1'b0;
  localparam logic [ATTEMPT_W-1:0] RST_IGNITION_ATTEMPTS = 8'd0;
  localparam logic [LIMIT_W-1:0]   RST_ALARM_DELAY_MS    = 16'd5000;
  localparam logic [LIMIT_W-1:0]   RST_RESET_PULSE_MS    = 16'd1000;
  localparam logic [LIMIT_W-1:0]   RST_DEBOUNCE_MS       = 16'd1000;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                fault_in;
    logic                cycle_active;
  } item_t;

  typedef struct packed {
    logic [STATE_W-1:0]   lock_state;
    logic                 reset_relay;
    logic                 lockout_alarm;
    logic [ATTEMPT_W-1:0] attempts_used;
  } result_t;

  typedef struct packed {
    logic                 gas_heating;
    logic [ATTEMPT_W-1:0] ignition_attempts;
    logic [LIMIT_W-1:0]   alarm_delay_ms;
    logic [LIMIT_W-1:0]   reset_pulse_ms;
    logic [LIMIT_W-1:0]   debounce_ms;
  } cfg_t;

  function automatic logic [STATE_W-1:0] mode_code(mode_e mode);
    logic [STATE_W-1:0] code;
    unique case (mode)
      MODE_OK:        code = BS_OK;
      MODE_RESETTING: code = BS_RESETTING;
      MODE_DEBOUNCE:  code = BS_DEBOUNCE;
      MODE_LOCKED:    code = BS_LOCKED;
      default:        code = BS_OK;
    endcase
    return code;
  endfunction

endpackage

// ----- hdl/bir_if.sv -----
// Channel interfaces of the burner ignition retry controller: input items,
// result items and configuration writes. Depends on bir_pkg.
interface bir_item_if import bir_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic                fault_in;
  logic                cycle_active;

  modport source (output valid, action, fault_in, cycle_active, input ready);
  modport sink   (input valid, action, fault_in, cycle_active, output ready);
endinterface

interface bir_res_if import bir_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATE_W-1:0]   lock_state;
  logic                 reset_relay;
  logic                 lockout_alarm;
  logic [ATTEMPT_W-1:0] attempts_used;

  modport source (output valid, lock_state, reset_relay, lockout_alarm, attempts_used,
                  input ready);
  modport sink   (input valid, lock_state, reset_relay, lockout_alarm, attempts_used,
                  output ready);
endinterface

interface bir_cfg_if import bir_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/bir_cfg_regs.sv -----
// Configuration register file of the burner ignition retry controller.
// Depends on bir_pkg and bir_cfg_if.
module bir_cfg_regs import bir_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  bir_cfg_if.sink   cfg_i,
  output cfg_t      cfg_o
);

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gas_heating       <= RST_GAS_HEATING;
      cfg_q.ignition_attempts <= RST_IGNITION_ATTEMPTS;
      cfg_q.alarm_delay_ms    <= RST_ALARM_DELAY_MS;
      cfg_q.reset_pulse_ms    <= RST_RESET_PULSE_MS;
      cfg_q.debounce_ms       <= RST_DEBOUNCE_MS;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_GAS_HEATING:       cfg_q.gas_heating       <= cfg_i.data[0];
        REG_IGNITION_ATTEMPTS: cfg_q.ignition_attempts <= cfg_i.data[ATTEMPT_W-1:0];
        REG_ALARM_DELAY_MS:    cfg_q.alarm_delay_ms    <= cfg_i.data[LIMIT_W-1:0];
        REG_RESET_PULSE_MS:    cfg_q.reset_pulse_ms    <= cfg_i.data[LIMIT_W-1:0];
        REG_DEBOUNCE_MS:       cfg_q.debounce_ms       <= cfg_i.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/bir_core.sv -----
// Lockout state machine, retry counter and saturating millisecond timer.
// Updates on each advanced item and presents the resulting output fields.
// Depends on bir_pkg.
module bir_core import bir_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  mode_e                 mode_q, mode_d;
  logic [TIMER_BITS-1:0] elapsed_q, elapsed_d;
  logic [ATTEMPT_W-1:0]  attempt_q, attempt_d;
  logic                  lockout_q, lockout_d;
  logic [TIMER_BITS-1:0] elapsed_t;
  logic [CMP_W-1:0]      elapsed_x;

  always_comb begin
    mode_d    = mode_q;
    elapsed_d = elapsed_q;
    attempt_d = attempt_q;
    lockout_d = lockout_q;
    elapsed_t = (elapsed_q != TIMER_MAX) ? elapsed_q + TIMER_BITS'(1) : elapsed_q;
    if (!item_i.cycle_active) begin
      elapsed_t = '0;
    end
    elapsed_x = CMP_W'(elapsed_t);
    unique case (item_i.action)
      ACT_TICK: begin
        elapsed_d = elapsed_t;
        if (!item_i.cycle_active) begin
          attempt_d = '0;
        end
        unique case (mode_q)
          MODE_OK: begin
            if (cfg_i.gas_heating && item_i.fault_in) begin
              if (elapsed_x >= CMP_W'(cfg_i.alarm_delay_ms)) begin
                if (attempt_d >= cfg_i.ignition_attempts) begin
                  lockout_d = 1'b1;
                  attempt_d = '0;
                  mode_d    = MODE_LOCKED;
                end else begin
                  attempt_d = attempt_d + ATTEMPT_W'(1);
                  mode_d    = MODE_RESETTING;
                end
                elapsed_d = '0;
              end
            end else begin
              elapsed_d = '0;
            end
          end
          MODE_RESETTING: begin
            if (item_i.fault_in) begin
              if (elapsed_x >= CMP_W'(cfg_i.reset_pulse_ms)) begin
                elapsed_d = '0;
                mode_d    = MODE_DEBOUNCE;
              end
            end else begin
              elapsed_d = '0;
              mode_d    = MODE_OK;
            end
          end
          MODE_DEBOUNCE: begin
            if (elapsed_x >= CMP_W'(cfg_i.debounce_ms)) begin
              elapsed_d = '0;
              mode_d    = MODE_OK;
            end
          end
          MODE_LOCKED: ;
          default: ;
        endcase
      end
      ACT_MANUAL_RESET: begin
        if (cfg_i.gas_heating) begin
          elapsed_d = '0;
          mode_d    = MODE_RESETTING;
        end
      end
      ACT_CLEAR_ALARM: lockout_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_OK;
      elapsed_q <= '0;
      attempt_q <= '0;
      lockout_q <= 1'b0;
    end else if (en_i) begin
      mode_q    <= mode_d;
      elapsed_q <= elapsed_d;
      attempt_q <= attempt_d;
      lockout_q <= lockout_d;
    end
  end

  assign res_o.lock_state    = mode_code(mode_d);
  assign res_o.reset_relay   = (mode_d == MODE_RESETTING);
  assign res_o.lockout_alarm = lockout_d;
  assign res_o.attempts_used = attempt_d;

`ifndef SYNTH
  a_locked_holds_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && (item_i.action == ACT_TICK) && (mode_q == MODE_LOCKED) |=> mode_q == MODE_LOCKED)
    else $error("locked state left on a tick");

  a_lock_latches_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(mode_q == MODE_LOCKED) |-> lockout_q && (attempt_q == '0))
    else $error("lockout entered without latched flag and cleared count");

  a_clear_drops_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && (item_i.action == ACT_CLEAR_ALARM) |=> !lockout_q)
    else $error("alarm clear left lockout flag set");
`endif

endmodule

// ----- hdl/burner_ignition_retry_controller.sv -----
// Top level of the burner ignition retry controller: input register, core, result register.
// Depends on bir_pkg, bir_if, bir_cfg_regs and bir_core.
//
//  channel   modport         payload                                          accept
//  item_i    bir_item_if     action, fault_in, cycle_active                   valid & ready
//  result_o  bir_res_if      lock_state, reset_relay, lockout_alarm,          valid & ready
//                            attempts_used
//  cfg_i     bir_cfg_if      index, data                                      valid & ready
//
// One item per cycle while results are taken; each item passes the input register, then the result register.
// The state update is one step of logic between the input register and the result register.
// An empty input register takes an item while a result waits; a full one holds until it advances.
// cfg_i is always ready. rst_ni clears all valid flags and the state and loads the configuration reset values.
module burner_ignition_retry_controller import bir_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  bir_item_if.sink  item_i,
  bir_res_if.source result_o,
  bir_cfg_if.sink   cfg_i
);

  cfg_t    cfg;
  item_t   item_q;
  logic    in_vld_q;
  result_t res_d, res_q;
  logic    out_vld_q;
  logic    adv;
  logic    in_take;

  assign adv          = in_vld_q && (!out_vld_q || result_o.ready);
  assign item_i.ready = !in_vld_q || adv;
  assign in_take      = item_i.valid && item_i.ready;

  bir_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  bir_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.action       <= item_i.action;
      item_q.fault_in     <= item_i.fault_in;
      item_q.cycle_active <= item_i.cycle_active;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid         = out_vld_q;
  assign result_o.lock_state    = res_q.lock_state;
  assign result_o.reset_relay   = res_q.reset_relay;
  assign result_o.lockout_alarm = res_q.lockout_alarm;
  assign result_o.attempts_used = res_q.attempts_used;

`ifndef SYNTH
  a_relay_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> res_q.reset_relay == (res_q.lock_state == BS_RESETTING))
    else $error("reset relay disagrees with lock state");

  a_adv_fills_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("advanced item produced no result");

  a_stalled_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |=> in_vld_q && $stable(item_q))
    else $error("stalled item lost from input register");
`endif

endmodule

// ----- tb/tb_burner_ignition_retry_controller.sv -----
// Self-checking testbench for burner_ignition_retry_controller.
// A directed table, then random items under several register settings, with results checked
// against table values or an in-bench lockout model. Depends on bir_pkg and bir_if.
`timescale 1ns / 100ps

module tb_burner_ignition_retry_controller;
  import bir_pkg::*;

  localparam logic [ACTION_W-1:0]  ACT_SPARE    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
  localparam int unsigned          HOLD_CYCLES  = 300;
  localparam int unsigned          TAIL_ITEMS   = 124;

  typedef struct packed {
    logic    known;
    result_t res;
  } fixed_result_t;

  typedef struct packed {
    logic [1:0] stage;
    item_t      it;
    logic       known;
    result_t    res;
  } dir_row_t;

  localparam result_t R_OK       = '{BS_OK,        1'b0, 1'b0, 8'd0};
  localparam result_t R_LOCK_ALM = '{BS_LOCKED,    1'b0, 1'b1, 8'd0};
  localparam result_t R_LOCK     = '{BS_LOCKED,    1'b0, 1'b0, 8'd0};
  localparam result_t R_RES      = '{BS_RESETTING, 1'b1, 1'b0, 8'd0};
  localparam result_t R_DEB      = '{BS_DEBOUNCE,  1'b0, 1'b0, 8'd0};
  localparam result_t R_NONE     = '0;

  localparam cfg_t DIR_CFG [3] = '{
    '{RST_GAS_HEATING, RST_IGNITION_ATTEMPTS, RST_ALARM_DELAY_MS, RST_RESET_PULSE_MS,
      RST_DEBOUNCE_MS},
    '{1'b1, 8'd0, 16'd0, 16'd0, 16'd0},
    '{1'b1, 8'd2, 16'd2, 16'd1, 16'd1}
  };

  localparam int DIR_ROWS = 26;
  localparam dir_row_t DIR [DIR_ROWS] = '{
    '{2'd0, '{ACT_TICK,         1'b0, 1'b0}, 1'b1, R_OK},
    '{2'd0, '{ACT_TICK,         1'b1, 1'b1}, 1'b1, R_OK},
    '{2'd0, '{ACT_MANUAL_RESET, 1'b1, 1'b1}, 1'b1, R_OK},
    '{2'd0, '{ACT_CLEAR_ALARM,  1'b0, 1'b0}, 1'b1, R_OK},
    '{2'd0, '{ACT_SPARE,        1'b1, 1'b1}, 1'b1, R_OK},
    '{2'd1, '{ACT_TICK,         1'b1, 1'b1}, 1'b1, R_LOCK_ALM},
    '{2'd1, '{ACT_TICK,         1'b1, 1'b0}, 1'b1, R_LOCK_ALM},
    '{2'd1, '{ACT_CLEAR_ALARM,  1'b1, 1'b1}, 1'b1, R_LOCK},
    '{2'd1, '{ACT_MANUAL_RESET, 1'b0, 1'b0}, 1'b1, R_RES},
    '{2'd1, '{ACT_TICK,         1'b0, 1'b1}, 1'b1, R_OK},
    '{2'd1, '{ACT_MANUAL_RESET, 1'b1, 1'b1}, 1'b1, R_RES},
    '{2'd1, '{ACT_TICK,         1'b1, 1'b1}, 1'b1, R_DEB},
    '{2'd1, '{ACT_TICK,         1'b0, 1'b0}, 1'b1, R_OK},
    '{2'd1, '{ACT_SPARE,        1'b0, 1'b0}, 1'b1, R_OK},
    '{2'd2, '{ACT_TICK,         1'b1, 1'b1}, 1'b0, R_NONE},
    '{2'd2, '{ACT_TICK,         1'b1, 1'b1}, 1'b0, R_NONE},
    '{2'd2, '{ACT_TICK,         1'b1, 1'b1}, 1'b0, R_NONE},
    '{2'd2, '{ACT_TICK,         1'b0, 1'b1}, 1'b0, R_NONE},
    '{2'd2, '{ACT_TICK,         1'b1, 1'b1}, 1'b0, R_NONE},
    '{2'd2, '{ACT_TICK,         1'b1, 1'b1}, 1'b0, R_NONE},
    '{2'd2, '{ACT_TICK,         1'b1, 1'b1}, 1'b0, R_NONE},
    '{2'd2, '{ACT_TICK,         1'b1, 1'b1}, 1'b0, R_NONE},
    '{2'd2, '{ACT_TICK,         1'b1, 1'b1}, 1'b0, R_NONE},
    '{2'd2, '{ACT_TICK,         1'b1, 1'b1}, 1'b0, R_NONE},
    '{2'd2, '{ACT_MANUAL_RESET, 1'b1, 1'b1}, 1'b0, R_NONE},
    '{2'd2, '{ACT_TICK,         1'b1, 1'b0}, 1'b0, R_NONE}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bir_item_if item_if ();
  bir_res_if  res_if ();
  bir_cfg_if  cfg_if ();

  burner_ignition_retry_controller dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(res_if),
    .cfg_i   (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cfg_t                  shadow_cfg  = DIR_CFG[0];
  logic [STATE_W-1:0]    burner_mode = BS_OK;
  logic [TIMER_BITS-1:0] elapsed_ms  = '0;
  logic [ATTEMPT_W-1:0]  attempts    = '0;
  logic                  lockout     = 1'b0;

  result_t       burner_status_q [$];
  fixed_result_t fixed_result_q [$];
  int unsigned   fail_count = 0;
  int unsigned   burst_left = 0;
  logic          alarm_lvl  = 1'b0;
  bit            hold_req   = 1'b0;

  function automatic result_t advance_burner(item_t it);
    result_t r;
    case (it.action)
      ACT_TICK: begin
        if (elapsed_ms != TIMER_MAX) elapsed_ms = elapsed_ms + 1'b1;
        if (!it.cycle_active) begin
          elapsed_ms = '0;
          attempts   = '0;
        end
        case (burner_mode)
          BS_OK: begin
            if (shadow_cfg.gas_heating && it.fault_in) begin
              if (elapsed_ms >= shadow_cfg.alarm_delay_ms) begin
                if (attempts >= shadow_cfg.ignition_attempts) begin
                  lockout     = 1'b1;
                  attempts    = '0;
                  burner_mode = BS_LOCKED;
                end else begin
                  attempts    = attempts + 1'b1;
                  burner_mode = BS_RESETTING;
                end
                elapsed_ms = '0;
              end
            end else begin
              elapsed_ms = '0;
            end
          end
          BS_RESETTING: begin
            if (!it.fault_in) begin
              burner_mode = BS_OK;
              elapsed_ms  = '0;
            end else if (elapsed_ms >= shadow_cfg.reset_pulse_ms) begin
              burner_mode = BS_DEBOUNCE;
              elapsed_ms  = '0;
            end
          end
          BS_DEBOUNCE: begin
            if (elapsed_ms >= shadow_cfg.debounce_ms) begin
              burner_mode = BS_OK;
              elapsed_ms  = '0;
            end
          end
          default: ;
        endcase
      end
      ACT_MANUAL_RESET: begin
        if (shadow_cfg.gas_heating) begin
          elapsed_ms  = '0;
          burner_mode = BS_RESETTING;
        end
      end
      ACT_CLEAR_ALARM: lockout = 1'b0;
      default: ;
    endcase
    r.lock_state    = burner_mode;
    r.reset_relay   = (burner_mode == BS_RESETTING);
    r.lockout_alarm = lockout;
    r.attempts_used = attempts;
    return r;
  endfunction

  task automatic log_failure(string msg);
    fail_count++;
    $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      log_failure($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  always @(posedge clk_i) begin : monitor_blk
    item_t         seen;
    result_t       got;
    result_t       want;
    result_t       predicted;
    fixed_result_t fixed;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_GAS_HEATING:       shadow_cfg.gas_heating       = cfg_if.data[0];
          REG_IGNITION_ATTEMPTS: shadow_cfg.ignition_attempts = cfg_if.data[ATTEMPT_W-1:0];
          REG_ALARM_DELAY_MS:    shadow_cfg.alarm_delay_ms    = cfg_if.data[LIMIT_W-1:0];
          REG_RESET_PULSE_MS:    shadow_cfg.reset_pulse_ms    = cfg_if.data[LIMIT_W-1:0];
          REG_DEBOUNCE_MS:       shadow_cfg.debounce_ms       = cfg_if.data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (res_if.valid && res_if.ready) begin
        got = '{res_if.lock_state, res_if.reset_relay, res_if.lockout_alarm,
                res_if.attempts_used};
        if (burner_status_q.size() == 0) begin
          log_failure($sformatf("result with nothing expected: %h", got));
        end else begin
          want = burner_status_q.pop_front();
          check_field("lock_state", 8'(got.lock_state), 8'(want.lock_state));
          check_field("reset_relay", 8'(got.reset_relay), 8'(want.reset_relay));
          check_field("lockout_alarm", 8'(got.lockout_alarm), 8'(want.lockout_alarm));
          check_field("attempts_used", got.attempts_used, want.attempts_used);
        end
      end
      if (item_if.valid && item_if.ready) begin
        seen      = '{item_if.action, item_if.fault_in, item_if.cycle_active};
        predicted = advance_burner(seen);
        fixed     = fixed_result_q.pop_front();
        burner_status_q.push_back(fixed.known ? fixed.res : predicted);
      end
    end
  end

  initial begin : receiver
    int unsigned seg_left;
    int unsigned seg_kind;
    int unsigned hold_cnt;
    logic [7:0]  stall_mask;
    logic        ready_next;
    seg_left   = 0;
    seg_kind   = 0;
    hold_cnt   = 0;
    stall_mask = 8'h01;
    res_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        ready_next = 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_kind   = $urandom_range(0, 2);
          seg_left   = $urandom_range(8, 60);
          stall_mask = 8'($urandom_range(1, 255));
        end
        seg_left--;
        case (seg_kind)
          0:       ready_next = 1'b1;
          1:       ready_next = ($urandom_range(0, 3) != 0);
          default: begin
            stall_mask = {stall_mask[6:0], stall_mask[7]};
            ready_next = stall_mask[0];
          end
        endcase
      end
      res_if.ready <= ready_next;
    end
  end

  task automatic drive_item(item_t it, logic known, result_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap        = $urandom_range(0, 5);
      if (gap != 0) begin
        item_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    fixed_result_q.push_back('{known, want});
    item_if.valid        <= 1'b1;
    item_if.action       <= it.action;
    item_if.fault_in     <= it.fault_in;
    item_if.cycle_active <= it.cycle_active;
    do @(posedge clk_i); while (!item_if.ready);
    @(negedge clk_i);
    burst_left--;
  endtask

  task automatic settle();
    item_if.valid <= 1'b0;
    while (burner_status_q.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
  endtask

  task automatic load_config(cfg_t c);
    logic [CFG_DATA_W-1:0] d;
    d    = CFG_DATA_W'($urandom);
    d[0] = c.gas_heating;
    write_reg(REG_GAS_HEATING, d);
    d                = CFG_DATA_W'($urandom);
    d[ATTEMPT_W-1:0] = c.ignition_attempts;
    write_reg(REG_IGNITION_ATTEMPTS, d);
    write_reg(REG_ALARM_DELAY_MS, c.alarm_delay_ms);
    write_reg(REG_RESET_PULSE_MS, c.reset_pulse_ms);
    write_reg(REG_DEBOUNCE_MS, c.debounce_ms);
    for (int k = IDX_SPARE_LO; k <= IDX_SPARE_HI; k++)
      write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
    cfg_if.valid <= 1'b0;
  endtask

  function automatic cfg_t rand_cfg(int unsigned max_ms);
    cfg_t c;
    c.gas_heating       = ($urandom_range(0, 7) != 0);
    c.ignition_attempts = ATTEMPT_W'($urandom_range(0, 4));
    c.alarm_delay_ms    = LIMIT_W'($urandom_range(0, max_ms));
    c.reset_pulse_ms    = LIMIT_W'($urandom_range(0, max_ms));
    c.debounce_ms       = LIMIT_W'($urandom_range(0, max_ms));
    return c;
  endfunction

  task automatic run_random(int unsigned n, int unsigned flip_pm, int unsigned idle_pm,
                            int unsigned noise_pm);
    item_t       it;
    int unsigned r;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 999) < flip_pm) alarm_lvl = !alarm_lvl;
      r = $urandom_range(0, 999);
      if (r >= noise_pm)          it.action = ACT_TICK;
      else if (r < noise_pm / 3)  it.action = ACT_MANUAL_RESET;
      else if (r < 2*noise_pm/3)  it.action = ACT_CLEAR_ALARM;
      else                        it.action = ACT_SPARE;
      if (it.action == ACT_TICK) begin
        it.fault_in     = alarm_lvl;
        it.cycle_active = ($urandom_range(0, 999) >= idle_pm);
      end else begin
        it.fault_in     = 1'($urandom);
        it.cycle_active = 1'($urandom);
      end
      drive_item(it, 1'b0, R_NONE);
    end
  endtask

  initial begin : stimulus
    int unsigned cur_stage;
    cfg_t        c;
    item_if.valid        <= 1'b0;
    item_if.action       <= ACT_TICK;
    item_if.fault_in     <= 1'b0;
    item_if.cycle_active <= 1'b0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= REG_GAS_HEATING;
    cfg_if.data          <= '0;
    cur_stage = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR[i].stage != cur_stage) begin
        settle();
        cur_stage = DIR[i].stage;
        load_config(DIR_CFG[cur_stage]);
      end
      drive_item(DIR[i].it, DIR[i].known, DIR[i].res);
    end

    settle();
    load_config(rand_cfg(6));
    hold_req = 1'b1;
    run_random(150, 150, 30, 60);

    settle();
    c = '{1'b0, 8'd255, 16'd0, 16'hFFFF, 16'd0};
    load_config(c);
    run_random(100, 150, 30, 90);

    settle();
    c = '{1'b1, 8'd255, 16'd0, 16'd0, 16'd0};
    load_config(c);
    alarm_lvl = 1'b1;
    run_random(850, 2, 0, 6);

    settle();
    load_config(rand_cfg(20));
    run_random(200, 100, 20, 60);

    settle();
    c = '{1'b1, 8'd1, 16'hFFFF, 16'd2, 16'd3};
    load_config(c);
    alarm_lvl = 1'b1;
    run_random(TAIL_ITEMS, 0, 0, 40);

    settle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin : watchdog
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- burner_ignition_retry_controller.f -----
hdl/bir_pkg.sv
hdl/bir_if.sv
hdl/bir_cfg_regs.sv
hdl/bir_core.sv
hdl/burner_ignition_retry_controller.sv
tb/tb_burner_ignition_retry_controller.sv
